### src/pia_pkg.sv
// shared types, codes and helpers for the padded integer to ascii converter
// no dependencies
package pia_pkg;

  localparam int VALUE_W = 64;
  localparam int BIT_CNT_W = $clog2(VALUE_W);
  // octal needs the most digits: ceil(64 / 3)
  localparam int NDIG = 22;
  localparam int DIG_W = 4;
  localparam int SCNT_W = $clog2(NDIG);

  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_HEXL = 3'd2;
  localparam logic [2:0] KIND_HEXU = 3'd3;
  localparam logic [2:0] KIND_OCT = 3'd4;
  localparam logic [2:0] KIND_PTR = 3'd5;

  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_X = 8'h78;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [5:0]  field_width;
    logic        left_just;
    logic        zero_fill;
  } num_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2
  } radix_t;

  typedef enum logic [1:0] {
    DOP_HOLD        = 2'd0,
    DOP_CLEAR       = 2'd1,
    DOP_SHIFT_BIT   = 2'd2,
    DOP_SHIFT_DIGIT = 2'd3
  } dig_op_t;

  typedef struct packed {
    dig_op_t op;
    radix_t  radix;
    logic    bit_in;
  } dig_ctl_t;

  function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CHR_UPPER_A : CHR_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CHR_ZERO + {4'h0, d};
    end else begin
      digit_char = base + {4'h0, d} - 8'd10;
    end
  endfunction

endpackage

### src/pia_digit_reg.sv
// digit register: builds decimal, hex or octal digits one value bit per cycle,
// then shifts digits out from the most significant end; uses pia_pkg
module pia_digit_reg
  import pia_pkg::*;
(
  input  logic             clk,
  input  dig_ctl_t         ctl,
  output logic [DIG_W-1:0] top_digit
);

  logic [NDIG-1:0][DIG_W-1:0] dig;
  logic [NDIG-1:0][DIG_W-1:0] dig_next;
  logic [NDIG-1:0][DIG_W-1:0] shifted;

  // per-digit cell: add-3 correction for decimal, then shift one bit up the chain
  always_comb begin
    logic             cin;
    logic [DIG_W-1:0] corr;
    cin = ctl.bit_in;
    for (int i = 0; i < NDIG; i++) begin
      corr = dig[i];
      if (ctl.radix == RADIX_DEC && dig[i] >= 4'd5) begin
        corr = dig[i] + 4'd3;
      end
      if (ctl.radix == RADIX_OCT) begin
        shifted[i] = {1'b0, corr[1:0], cin};
        cin = corr[2];
      end else begin
        shifted[i] = {corr[2:0], cin};
        cin = corr[3];
      end
    end
  end

  always_comb begin
    case (ctl.op)
      DOP_HOLD:        dig_next = dig;
      DOP_CLEAR:       dig_next = '0;
      DOP_SHIFT_BIT:   dig_next = shifted;
      DOP_SHIFT_DIGIT: dig_next = {dig[NDIG-2:0], {DIG_W{1'b0}}};
      default:         dig_next = dig;
    endcase
  end

  always_ff @(posedge clk) begin
    dig <= dig_next;
  end

  assign top_digit = dig[NDIG-1];

endmodule

### src/padded_integer_to_ascii_top.sv
// padded integer to ascii converter, printf-style integer conversions
// digits are built bit-serially, one value bit per cycle, then leading zeros are
// skipped, then characters go into the output register one per cycle while the
// receiver does not stall; a new item is taken only after the last character of
// the previous one has gone into the output register
// reset: synchronous active-high rst empties the output and returns to idle
module padded_integer_to_ascii_top
  import pia_pkg::*;
#(
  parameter int WIDTH_MAX = 63
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  num_valid,
  output logic  num_stall,
  input  num_t  num,
  output logic  text_valid,
  input  logic  text_stall,
  output text_t text
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // order of the three text segments
  typedef enum logic [1:0] {
    ORD_PRE_PAD_DIG = 2'd0,
    ORD_PRE_DIG_PAD = 2'd1,
    ORD_PAD_PRE_DIG = 2'd2
  } order_t;

  state_t               state;
  logic [VALUE_W-1:0]   mag;
  logic [BIT_CNT_W-1:0] bcnt;
  logic [SCNT_W-1:0]    scnt;
  radix_t               radix;
  logic                 upper;
  logic                 neg;
  logic                 ptr;
  logic                 zp;
  logic [5:0]           w;
  order_t               order;
  logic [1:0]           pre_left;
  logic [5:0]           pad_left;
  logic [SCNT_W-1:0]    dig_left;
  logic [5:0]           rem;

  logic [DIG_W-1:0] top_digit;
  dig_ctl_t         dctl;

  logic              accept;
  logic              is_neg;
  logic [5:0]        w_eff;
  logic              scan_done;
  logic [SCNT_W-1:0] nd_calc;
  logic [1:0]        np_calc;
  logic [5:0]        total_calc;
  logic [5:0]        pad_calc;
  logic              emit;
  logic              sel_pre;
  logic              sel_pad;
  logic              sel_dig;
  logic [7:0]        ch;
  logic [7:0]        fill;

  assign num_stall = (state != S_IDLE);
  assign accept = num_valid && (state == S_IDLE);

  // sign, and width capped at WIDTH_MAX, taken at the accept edge
  assign is_neg = (num.kind == KIND_SDEC) && num.value[VALUE_W-1];
  assign w_eff = (num.field_width > 6'(WIDTH_MAX)) ? 6'(WIDTH_MAX) : num.field_width;

  // leading-zero skip ends on a nonzero top digit, or with one digit left
  assign scan_done = (top_digit != '0) || (scnt == SCNT_W'(NDIG - 1));
  assign nd_calc = SCNT_W'(NDIG) - scnt;
  assign np_calc = neg ? 2'd1 : (ptr ? 2'd2 : 2'd0);
  assign total_calc = 6'(nd_calc) + 6'(np_calc);
  assign pad_calc = (w > total_calc) ? (w - total_calc) : 6'd0;

  // output register free this cycle
  assign emit = (state == S_EMIT) && (!text_valid || !text_stall);

  // pick the segment the next character comes from
  always_comb begin
    sel_pre = 1'b0;
    sel_pad = 1'b0;
    case (order)
      ORD_PRE_PAD_DIG: begin
        sel_pre = (pre_left != 2'd0);
        sel_pad = !sel_pre && (pad_left != 6'd0);
      end
      ORD_PRE_DIG_PAD: begin
        sel_pre = (pre_left != 2'd0);
        sel_pad = !sel_pre && (dig_left == '0);
      end
      ORD_PAD_PRE_DIG: begin
        sel_pad = (pad_left != 6'd0);
        sel_pre = !sel_pad && (pre_left != 2'd0);
      end
      default: begin
        sel_pre = (pre_left != 2'd0);
        sel_pad = !sel_pre && (pad_left != 6'd0);
      end
    endcase
    sel_dig = !sel_pre && !sel_pad;
  end

  // zeros only between prefix and digits; trailing or leading padding is spaces
  assign fill = (order == ORD_PRE_PAD_DIG && zp) ? CHR_ZERO : CHR_SPACE;

  always_comb begin
    if (sel_pre) begin
      if (neg) begin
        ch = CHR_MINUS;
      end else if (pre_left == 2'd2) begin
        ch = CHR_ZERO;
      end else begin
        ch = CHR_X;
      end
    end else if (sel_pad) begin
      ch = fill;
    end else begin
      ch = digit_char(top_digit, upper);
    end
  end

  // digit register control
  always_comb begin
    dctl.radix = radix;
    dctl.bit_in = mag[VALUE_W-1];
    dctl.op = DOP_HOLD;
    case (state)
      S_IDLE: if (accept) dctl.op = DOP_CLEAR;
      S_CONV: dctl.op = DOP_SHIFT_BIT;
      S_SCAN: if (!scan_done) dctl.op = DOP_SHIFT_DIGIT;
      S_EMIT: if (emit && sel_dig) dctl.op = DOP_SHIFT_DIGIT;
      default: dctl.op = DOP_HOLD;
    endcase
  end

  pia_digit_reg u_digits (
    .clk       (clk),
    .ctl       (dctl),
    .top_digit (top_digit)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      text_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          // unused kinds are taken and dropped
          if (accept && num.kind <= KIND_PTR) state <= S_CONV;
        end
        S_CONV: if (bcnt == BIT_CNT_W'(VALUE_W - 1)) state <= S_SCAN;
        S_SCAN: if (scan_done) state <= S_EMIT;
        S_EMIT: if (emit && rem == 6'd1) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (emit) begin
        text_valid <= 1'b1;
      end else if (!text_stall) begin
        text_valid <= 1'b0;
      end
    end
  end

  // item payload, counters and output register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          mag <= is_neg ? (~num.value + 64'd1) : num.value;
          bcnt <= '0;
          neg <= is_neg;
          ptr <= (num.kind == KIND_PTR);
          upper <= (num.kind == KIND_HEXU);
          zp <= num.zero_fill;
          w <= w_eff;
          if (num.kind == KIND_SDEC || num.kind == KIND_UDEC) begin
            radix <= RADIX_DEC;
          end else if (num.kind == KIND_OCT) begin
            radix <= RADIX_OCT;
          end else begin
            radix <= RADIX_HEX;
          end
          if (num.kind == KIND_PTR || (!num.left_just && num.zero_fill)) begin
            order <= ORD_PRE_PAD_DIG;
          end else if (num.left_just) begin
            order <= ORD_PRE_DIG_PAD;
          end else begin
            order <= ORD_PAD_PRE_DIG;
          end
        end
      end
      S_CONV: begin
        mag <= {mag[VALUE_W-2:0], 1'b0};
        bcnt <= bcnt + 1'b1;
        scnt <= '0;
      end
      S_SCAN: begin
        if (scan_done) begin
          dig_left <= nd_calc;
          pre_left <= np_calc;
          pad_left <= pad_calc;
          rem <= pad_calc + total_calc;
        end else begin
          scnt <= scnt + 1'b1;
        end
      end
      S_EMIT: begin
        if (emit) begin
          rem <= rem - 6'd1;
          if (sel_pre) pre_left <= pre_left - 2'd1;
          if (sel_pad) pad_left <= pad_left - 6'd1;
          if (sel_dig) dig_left <= dig_left - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      text.character <= ch;
      text.last <= (rem == 6'd1);
    end
  end

endmodule

### tb/tb_padded_integer_to_ascii_top.sv
// self-checking testbench for padded_integer_to_ascii_top: directed and random conversions,
// each predicted as a character string and compared one character at a time with the output
// depends on pia_pkg (item types, kind codes, character constants) and the block itself
module tb_padded_integer_to_ascii_top;
  import pia_pkg::*;

  // same cap on the field width as the block's default parameter
  localparam int FIELD_CAP = 63;
  // random items per idling phase, ignored kinds not counted
  localparam int PHASE_ITEMS = 48;
  // long receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES = 3000;
  // settle time after the last character, covers the worst conversion latency
  localparam int DRAIN_CYCLES = 250;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  num_valid = 1'b0;
  logic  num_stall;
  num_t  num = '0;
  logic  text_valid;
  logic  text_stall = 1'b0;
  text_t text;

  // stimulus side
  num_t pending_nums [$];
  int   nums_queued = 0;
  int   nums_accepted = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  // set at a rising edge that took the item on num
  logic num_taken = 1'b0;

  // long hold-off request: the stimulus bumps hold_req, the stall process answers
  int   hold_req = 0;
  int   hold_done = 0;
  int   hold_left = 0;

  // predicted characters, oldest first
  text_t expected_text [$];
  text_t want;
  int    mismatches = 0;

  padded_integer_to_ascii_top DUT (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .num       (num),
    .text_valid(text_valid),
    .text_stall(text_stall),
    .text      (text)
  );

  always #5 clk = ~clk;

  // printf-style formatting of one item, characters appended to expected_text
  function automatic void format_number(input num_t n);
    logic        negative;
    logic [63:0] mag;
    logic [3:0]  d;
    logic [7:0]  ch;
    logic [7:0]  hex_base;
    int unsigned w;
    int unsigned total;
    int unsigned pad;
    logic [7:0]  digs [$];
    logic [7:0]  pre [$];
    logic [7:0]  line [$];
    text_t       t;
    if (n.kind > KIND_PTR) begin
      // unused kinds produce nothing
      return;
    end
    w = n.field_width;
    if (w > FIELD_CAP) begin
      w = FIELD_CAP;
    end
    negative = (n.kind == KIND_SDEC) && n.value[63];
    // two's complement negate also handles the most negative value
    mag = negative ? -n.value : n.value;
    hex_base = (n.kind == KIND_HEXU) ? CHR_UPPER_A : CHR_LOWER_A;
    // digits come out least significant first, so build the string from the front
    do begin
      case (n.kind)
        KIND_SDEC, KIND_UDEC: begin
          d = 4'(mag % 64'd10);
          mag = mag / 64'd10;
        end
        KIND_OCT: begin
          d = {1'b0, mag[2:0]};
          mag = mag >> 3;
        end
        default: begin
          d = mag[3:0];
          mag = mag >> 4;
        end
      endcase
      ch = (d < 4'd10) ? CHR_ZERO + 8'(d) : hex_base + 8'(d) - 8'd10;
      digs.push_front(ch);
    end while (mag != 64'd0);
    if (negative) begin
      pre.push_back(CHR_MINUS);
    end else if (n.kind == KIND_PTR) begin
      pre.push_back(CHR_ZERO);
      pre.push_back(CHR_X);
    end
    total = pre.size() + digs.size();
    pad = (w > total) ? w - total : 0;
    if (n.kind == KIND_PTR || (!n.left_just && n.zero_fill)) begin
      // prefix, then padding, then digits; pointers ignore left align
      line = pre;
      for (int k = 0; k < pad; k++) line.push_back(n.zero_fill ? CHR_ZERO : CHR_SPACE);
      foreach (digs[k]) line.push_back(digs[k]);
    end else if (n.left_just) begin
      line = pre;
      foreach (digs[k]) line.push_back(digs[k]);
      for (int k = 0; k < pad; k++) line.push_back(CHR_SPACE);
    end else begin
      for (int k = 0; k < pad; k++) line.push_back(CHR_SPACE);
      foreach (pre[k]) line.push_back(pre[k]);
      foreach (digs[k]) line.push_back(digs[k]);
    end
    foreach (line[k]) begin
      t.character = line[k];
      t.last = (k == line.size() - 1);
      expected_text.push_back(t);
    end
  endfunction

  function automatic num_t make_num(input logic [2:0] kind, input logic [63:0] value,
                                    input logic [5:0] w, input logic la, input logic zp);
    num_t n;
    n.kind = kind;
    n.value = value;
    n.field_width = w;
    n.left_just = la;
    n.zero_fill = zp;
    return n;
  endfunction

  // random item: values spread over magnitudes so short and long digit strings both show up
  function automatic num_t random_num();
    num_t n;
    n.kind = ($urandom_range(99) < 4) ? 3'd6 + 3'($urandom_range(1)) : 3'($urandom_range(5));
    case ($urandom_range(9))
      0: n.value = 64'd0;
      1: n.value = '1;
      2: n.value = {1'b1, 63'd0};
      3: n.value = 64'($urandom_range(999));
      4, 5: n.value = {$urandom, $urandom};
      default: n.value = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    // signed decimal values are negated half the time
    if (n.kind == KIND_SDEC && $urandom_range(1)) begin
      n.value = -n.value;
    end
    n.field_width = $urandom_range(1) ? 6'($urandom_range(12)) : 6'($urandom_range(63));
    n.left_just = 1'($urandom_range(1));
    n.zero_fill = 1'($urandom_range(1));
    return n;
  endfunction

  function automatic void queue_num(input num_t n);
    pending_nums.push_back(n);
    nums_queued++;
  endfunction

  // driver: changes on the falling edge, holds a stalled item, idles at random
  always @(negedge clk) begin
    if (rst) begin
      num_valid <= 1'b0;
    end else if (!num_valid || num_taken) begin
      // num_taken tells whether the item on num went in at the last rise
      if (pending_nums.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        num <= pending_nums.pop_front();
        num_valid <= 1'b1;
      end else begin
        num_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random idling, or a long hold-off counted down here
  always @(negedge clk) begin
    if (hold_left != 0) begin
      text_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HOLD_CYCLES;
      text_stall <= 1'b1;
    end else begin
      text_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // rising edge: predict each accepted item, then check each accepted character
  always @(posedge clk) begin
    num_taken <= !rst && num_valid && !num_stall;
    if (!rst && num_valid && !num_stall) begin
      format_number(num);
      nums_accepted <= nums_accepted + 1;
    end
    if (!rst && text_valid && !text_stall) begin
      if (expected_text.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected character: got %h last %b", text.character, text.last);
        end
      end else begin
        want = expected_text.pop_front();
        if (text.character !== want.character || text.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("character mismatch: expected %h last %b, got %h last %b",
                     want.character, want.last, text.character, text.last);
          end
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    int count;
    num_t n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, every kind, the special cases
    send_idle_pct = 13;
    recv_idle_pct = 62;
    queue_num(make_num(KIND_SDEC, 64'd0, 6'd0, 1'b0, 1'b0));          // zero prints one digit
    queue_num(make_num(KIND_SDEC, '1, 6'd0, 1'b0, 1'b0));             // minus one
    queue_num(make_num(KIND_SDEC, {1'b1, 63'd0}, 6'd0, 1'b0, 1'b0));  // most negative
    queue_num(make_num(KIND_SDEC, {1'b0, {63{1'b1}}}, 6'd63, 1'b0, 1'b0));
    queue_num(make_num(KIND_SDEC, -64'd42, 6'd10, 1'b0, 1'b1));       // sign once before zeros
    queue_num(make_num(KIND_SDEC, -64'd42, 6'd10, 1'b1, 1'b1));       // left align beats zero pad
    queue_num(make_num(KIND_SDEC, -64'd42, 6'd10, 1'b0, 1'b0));
    queue_num(make_num(KIND_SDEC, 64'd12345, 6'd3, 1'b0, 1'b1));      // text longer than width
    queue_num(make_num(KIND_SDEC, 64'd5, 6'd63, 1'b1, 1'b1));
    queue_num(make_num(KIND_UDEC, '1, 6'd0, 1'b0, 1'b0));
    queue_num(make_num(KIND_UDEC, 64'd0, 6'd63, 1'b0, 1'b1));
    queue_num(make_num(KIND_UDEC, 64'd7, 6'd63, 1'b1, 1'b0));
    queue_num(make_num(KIND_HEXL, 64'hdeadbeefcafef00d, 6'd0, 1'b0, 1'b0));
    queue_num(make_num(KIND_HEXU, 64'hdeadbeefcafef00d, 6'd20, 1'b0, 1'b1));
    queue_num(make_num(KIND_HEXU, 64'habcdef, 6'd8, 1'b1, 1'b0));
    queue_num(make_num(KIND_OCT, '1, 6'd0, 1'b0, 1'b0));              // longest digit string
    queue_num(make_num(KIND_OCT, 64'd8, 6'd5, 1'b0, 1'b1));
    queue_num(make_num(KIND_PTR, 64'd0, 6'd0, 1'b0, 1'b0));
    queue_num(make_num(KIND_PTR, 64'h1234, 6'd10, 1'b0, 1'b1));       // zeros after 0x
    queue_num(make_num(KIND_PTR, '1, 6'd63, 1'b1, 1'b1));             // pointer ignores left align
    queue_num(make_num(KIND_PTR, 64'hab, 6'd8, 1'b1, 1'b0));
    queue_num(make_num(3'd6, 64'd1, 6'd10, 1'b0, 1'b0));              // unused kinds, no output
    queue_num(make_num(3'd7, '1, 6'd63, 1'b1, 1'b1));
    queue_num(make_num(KIND_HEXL, 64'd15, 6'd1, 1'b0, 1'b0));

    // random, three idling phases: sender light, receiver light, none
    for (int phase = 0; phase < 3; phase++) begin
      while (nums_accepted != nums_queued) @(posedge clk);
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 13 : 0;
      count = 0;
      while (count < PHASE_ITEMS) begin
        n = random_num();
        queue_num(n);
        if (n.kind <= KIND_PTR) begin
          count++;
        end
      end
      // last phase: hold the output off with plenty still to send so the input backs up
      if (phase == 2) begin
        @(posedge clk);
        hold_req++;
      end
    end

    // drain: everything sent, every character seen, then a quiet stretch
    while (nums_accepted != nums_queued) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
